// ===== rtl/rvc_pkg.sv =====
// Shared types, codes and helpers for the RV32IMA step core.
// No dependencies; imported by rvc_mdu, rv32ima_core_step_core and tb_top.
package rvc_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    // actions
    localparam logic [1:0] ACT_EXEC  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_HALTED   = 3'd1;
    localparam logic [2:0] ST_EXIT     = 3'd2;
    localparam logic [2:0] ST_WRITE    = 3'd3;
    localparam logic [2:0] ST_SYSCALL  = 3'd4;
    localparam logic [2:0] ST_EBREAK   = 3'd5;
    localparam logic [2:0] ST_ILLEGAL  = 3'd6;
    localparam logic [2:0] ST_MEMFAULT = 3'd7;

    // opcodes
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_FENCE  = 7'h0F;
    localparam logic [6:0] OP_SYSTEM = 7'h73;
    localparam logic [6:0] OP_AMO    = 7'h2F;

    localparam logic [31:0] INS_ECALL  = 32'h0000_0073;
    localparam logic [31:0] INS_EBREAK = 32'h0010_0073;
    localparam logic [31:0] SYS_EXIT   = 32'd93;
    localparam logic [31:0] SYS_WRITE  = 32'd64;

    // AMO funct5
    localparam logic [4:0] AMO_ADD  = 5'd0;
    localparam logic [4:0] AMO_SWAP = 5'd1;
    localparam logic [4:0] AMO_LR   = 5'd2;
    localparam logic [4:0] AMO_SC   = 5'd3;
    localparam logic [4:0] AMO_XOR  = 5'd4;
    localparam logic [4:0] AMO_OR   = 5'd8;
    localparam logic [4:0] AMO_AND  = 5'd12;
    localparam logic [4:0] AMO_MIN  = 5'd16;
    localparam logic [4:0] AMO_MAX  = 5'd20;
    localparam logic [4:0] AMO_MINU = 5'd24;
    localparam logic [4:0] AMO_MAXU = 5'd28;

    // counter CSRs
    localparam logic [11:0] CSR_CYCLE     = 12'hC00;
    localparam logic [11:0] CSR_TIME      = 12'hC01;
    localparam logic [11:0] CSR_INSTRET   = 12'hC02;
    localparam logic [11:0] CSR_CYCLEH    = 12'hC80;
    localparam logic [11:0] CSR_TIMEH     = 12'hC81;
    localparam logic [11:0] CSR_INSTRETH  = 12'hC82;
    localparam logic [11:0] CSR_MCYCLE    = 12'hB00;
    localparam logic [11:0] CSR_MINSTRET  = 12'hB02;
    localparam logic [11:0] CSR_MCYCLEH   = 12'hB80;
    localparam logic [11:0] CSR_MINSTRETH = 12'hB82;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] address;
        logic [31:0] write_word;
    } core_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] read_word;
        logic [31:0] executed_pc;
        logic [31:0] instruction;
        logic [31:0] syscall_number;
        logic [31:0] syscall_arg0;
        logic [31:0] syscall_arg1;
        logic [31:0] syscall_arg2;
    } core_out_t;

    typedef struct packed {
        logic        start;
        logic [2:0]  funct3;
        logic [31:0] a;
        logic [31:0] b;
    } mdu_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } mdu_rsp_t;

    // true when all n bytes from a lie inside memory
    function automatic logic fits(input logic [31:0] a, input logic [2:0] n);
        logic [32:0] top;
        begin
            top = {1'b0, a} + {30'd0, n};
            return top <= 33'(MEM_BYTES);
        end
    endfunction

endpackage

// ===== rtl/rvc_mdu.sv =====
// Iterative multiply/divide unit: a 33-bit adder for multiply and a 34-bit subtractor for divide, one bit per cycle.
// Depends on rvc_pkg.
module rvc_mdu (
    input  logic              clk,
    input  logic              rst_n,
    input  rvc_pkg::mdu_req_t req,
    output rvc_pkg::mdu_rsp_t rsp
);
    import rvc_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_RUN  = 3'b010,
        M_FIN  = 3'b100
    } mstate_t;

    mstate_t     state_reg, state_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] opb_reg, opb_next;
    logic [31:0] a_reg, a_next;
    logic [2:0]  f3_reg, f3_next;
    logic        na_reg, na_next;
    logic        nb_reg, nb_next;
    logic        zero_reg, zero_next;
    logic [4:0]  cnt_reg, cnt_next;

    logic        is_div, sa, sb;
    logic [32:0] msum;
    logic [32:0] dsh;
    logic [33:0] ddiff;
    logic        dge;
    logic [63:0] prod, prod_s;
    logic [31:0] quo_s, rem_s;

    assign is_div = req.funct3[2];
    assign sa = (req.funct3 == 3'd1) || (req.funct3 == 3'd2) ||
                (req.funct3 == 3'd4) || (req.funct3 == 3'd6);
    assign sb = (req.funct3 == 3'd1) || (req.funct3 == 3'd4) || (req.funct3 == 3'd6);

    assign msum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, opb_reg} : 33'd0);
    assign dsh   = {hi_reg, lo_reg[31]};
    assign ddiff = {1'b0, dsh} - {2'b00, opb_reg};
    assign dge   = !ddiff[33];

    assign prod   = {hi_reg, lo_reg};
    assign prod_s = (na_reg ^ nb_reg) ? (64'd0 - prod) : prod;
    assign quo_s  = (na_reg ^ nb_reg) ? (32'd0 - lo_reg) : lo_reg;
    assign rem_s  = na_reg ? (32'd0 - hi_reg) : hi_reg;

    always_comb
    begin
        state_next = state_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        opb_next   = opb_reg;
        a_next     = a_reg;
        f3_next    = f3_reg;
        na_next    = na_reg;
        nb_next    = nb_reg;
        zero_next  = zero_reg;
        cnt_next   = cnt_reg;
        rsp.done   = 1'b0;
        rsp.result = '0;
        unique case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    f3_next   = req.funct3;
                    a_next    = req.a;
                    na_next   = sa & req.a[31];
                    nb_next   = sb & req.b[31];
                    hi_next   = '0;
                    lo_next   = (sa & req.a[31]) ? (32'd0 - req.a) : req.a;
                    opb_next  = (sb & req.b[31]) ? (32'd0 - req.b) : req.b;
                    cnt_next  = '0;
                    zero_next = is_div && (req.b == 32'd0);
                    state_next = (is_div && (req.b == 32'd0)) ? M_FIN : M_RUN;
                end
            end
            M_RUN:
            begin
                if (f3_reg[2])
                begin
                    hi_next = dge ? ddiff[31:0] : dsh[31:0];
                    lo_next = {lo_reg[30:0], dge};
                end
                else
                begin
                    hi_next = msum[32:1];
                    lo_next = {msum[0], lo_reg[31:1]};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = M_FIN;
            end
            M_FIN:
            begin
                rsp.done = 1'b1;
                unique case (f3_reg)
                    3'd0:    rsp.result = prod_s[31:0];
                    3'd1,
                    3'd2,
                    3'd3:    rsp.result = prod_s[63:32];
                    3'd4:    rsp.result = zero_reg ? 32'hFFFF_FFFF : quo_s;
                    3'd5:    rsp.result = zero_reg ? 32'hFFFF_FFFF : lo_reg;
                    3'd6:    rsp.result = zero_reg ? a_reg : rem_s;
                    default: rsp.result = zero_reg ? a_reg : hi_reg;
                endcase
                state_next = M_IDLE;
            end
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= M_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        opb_reg  <= opb_next;
        a_reg    <= a_next;
        f3_reg   <= f3_next;
        na_reg   <= na_next;
        nb_reg   <= nb_next;
        zero_reg <= zero_next;
        cnt_reg  <= cnt_next;
    end

    // a start is only issued while the unit is free
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == M_IDLE)
        else $error("mdu started while busy");
    a_fin_one: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == M_FIN |=> state_reg == M_IDLE)
        else $error("mdu result held more than one cycle");
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == M_RUN && cnt_reg != 5'd31) |=> state_reg == M_RUN)
        else $error("mdu left iteration early");

endmodule

// ===== rtl/rv32ima_core_step_core.sv =====
// RV32IMA step core: sequencer, register file, CSR file and byte memory.
// Depends on rvc_pkg and rvc_mdu.
//
// One word per start: execute one instruction at pc, or write / read a
// little-endian memory word. After reset the core clears its 4096-entry CSR
// file, one entry a cycle, and holds busy high until the clear is through.
// The memory has a single byte-wide port, which sets the pace: fetches,
// loads, stores and AMOs move one byte at a time. An out-of-range word write
// or read, an ignored action or a halted execute goes straight to the result.
// MUL/DIV run in the bit-serial multiply/divide unit, which skips the
// iteration on a division by zero. The result shows on response for one
// cycle with done high; the receiver cannot stall it.
module rv32ima_core_step_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  rvc_pkg::core_in_t  command,
    output logic               busy,
    output logic               done,
    output rvc_pkg::core_out_t response
);
    import rvc_pkg::*;

    typedef enum logic [13:0] {
        S_CLEAR  = 14'b00000000000001,
        S_IDLE   = 14'b00000000000010,
        S_MRD    = 14'b00000000000100,
        S_MWR    = 14'b00000000001000,
        S_RA     = 14'b00000000010000,
        S_RB     = 14'b00000000100000,
        S_EXEC   = 14'b00000001000000,
        S_LOADED = 14'b00000010000000,
        S_MD     = 14'b00000100000000,
        S_CSR    = 14'b00001000000000,
        S_ECALL  = 14'b00010000000000,
        S_AMO    = 14'b00100000000000,
        S_WB     = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic [2:0]  n;
        logic [2:0]  cnt;
        logic        to_ins;
        state_t      ret;
        logic [31:0] ins;
        logic [31:0] data;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] res;
        logic [4:0]  wrd;
        logic        wb;
        logic        fault;
        logic [2:0]  st;
        logic [31:0] pc;
        logic [31:0] npc;
        logic [63:0] cyc;
        logic        resv_v;
        logic [31:0] resv_a;
        logic        halted;
        logic [11:0] clr;
        core_out_t   out;
    } ctx_t;

    state_t state_reg, state_next;
    ctx_t   ctx_reg, ctx_next;

    // main memory port
    logic [7:0]        main_mem [MEM_BYTES];
    logic [7:0]        mem_q_reg;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_idx;
    logic [7:0]        mem_wd;
    logic [31:0]       mem_addr32;

    // register file
    logic [31:0] rf_mem [32];
    logic [31:0] rf_valid_reg;
    logic [31:0] rf_q_reg;
    logic        rf_v_reg;
    logic [4:0]  rf_raddr;
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wd;
    logic [31:0] rf_val;

    // CSR file
    logic [31:0] csr_mem [4096];
    logic [31:0] csr_q_reg;
    logic [11:0] csr_idx;
    logic        csr_we;
    logic [31:0] csr_wd;

    mdu_req_t mdu_req;
    mdu_rsp_t mdu_rsp;

    // decode
    logic [31:0] ins;
    logic [6:0]  opc;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  f5;
    logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u, pc4;
    logic [31:0] ld_addr, st_addr;

    // shared ALU
    logic [31:0] alu_x, alu_y, alu_res;
    logic [4:0]  alu_sh;
    logic        alu_alt;
    logic        br_take;

    // CSR / AMO helpers
    logic        csr_lo, csr_hi, csr_ro;
    logic [31:0] csr_old, csr_src, csr_nv;
    logic [31:0] amo_nv;
    logic        amo_ok;
    logic [4:0]  bpos;

    assign ins   = ctx_reg.ins;
    assign opc   = ins[6:0];
    assign rd    = ins[11:7];
    assign f3    = ins[14:12];
    assign rs1   = ins[19:15];
    assign rs2   = ins[24:20];
    assign f7    = ins[31:25];
    assign f5    = ins[31:27];
    assign imm_i = {{20{ins[31]}}, ins[31:20]};
    assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    assign imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    assign imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    assign imm_u = {ins[31:12], 12'd0};
    assign pc4   = ctx_reg.pc + 32'd4;

    assign rf_val  = rf_v_reg ? rf_q_reg : 32'd0;
    assign ld_addr = ctx_reg.a + imm_i;
    assign st_addr = ctx_reg.a + imm_s;

    assign mem_addr32 = ctx_reg.addr + {29'd0, ctx_reg.cnt};
    assign bpos       = {ctx_reg.cnt[1:0] - 2'd1, 3'b000};

    assign alu_x   = ctx_reg.a;
    assign alu_y   = (opc == OP_REG) ? rf_val : imm_i;
    assign alu_sh  = (opc == OP_REG) ? rf_val[4:0] : rs2;
    assign alu_alt = (f7 != 7'd0) && ((opc == OP_REG) || (f3 == 3'd5));

    always_comb
    begin
        unique case (f3)
            3'd0:    alu_res = alu_alt ? (alu_x - alu_y) : (alu_x + alu_y);
            3'd1:    alu_res = alu_x << alu_sh;
            3'd2:    alu_res = {31'd0, $signed(alu_x) < $signed(alu_y)};
            3'd3:    alu_res = {31'd0, alu_x < alu_y};
            3'd4:    alu_res = alu_x ^ alu_y;
            3'd5:    alu_res = alu_alt ? 32'($signed(alu_x) >>> alu_sh) : (alu_x >> alu_sh);
            3'd6:    alu_res = alu_x | alu_y;
            default: alu_res = alu_x & alu_y;
        endcase
    end

    always_comb
    begin
        unique case (f3)
            3'd0:    br_take = ctx_reg.a == rf_val;
            3'd1:    br_take = ctx_reg.a != rf_val;
            3'd4:    br_take = $signed(ctx_reg.a) < $signed(rf_val);
            3'd5:    br_take = !($signed(ctx_reg.a) < $signed(rf_val));
            3'd6:    br_take = ctx_reg.a < rf_val;
            3'd7:    br_take = ctx_reg.a >= rf_val;
            default: br_take = 1'b0;
        endcase
    end

    // counter aliases
    assign csr_lo = (ins[31:20] == CSR_CYCLE) || (ins[31:20] == CSR_MCYCLE) ||
                    (ins[31:20] == CSR_TIME) || (ins[31:20] == CSR_INSTRET) ||
                    (ins[31:20] == CSR_MINSTRET);
    assign csr_hi = (ins[31:20] == CSR_CYCLEH) || (ins[31:20] == CSR_MCYCLEH) ||
                    (ins[31:20] == CSR_TIMEH) || (ins[31:20] == CSR_INSTRETH) ||
                    (ins[31:20] == CSR_MINSTRETH);
    assign csr_ro = (ins[31:20] == CSR_CYCLE) || (ins[31:20] == CSR_TIME) ||
                    (ins[31:20] == CSR_INSTRET) || (ins[31:20] == CSR_CYCLEH) ||
                    (ins[31:20] == CSR_TIMEH) || (ins[31:20] == CSR_INSTRETH);
    assign csr_old = csr_lo ? ctx_reg.cyc[31:0] : (csr_hi ? ctx_reg.cyc[63:32] : csr_q_reg);
    assign csr_src = f3[2] ? {27'd0, rs1} : ctx_reg.a;

    always_comb
    begin
        unique case (f3[1:0])
            2'd1:    csr_nv = csr_src;
            2'd2:    csr_nv = csr_old | csr_src;
            2'd3:    csr_nv = csr_old & ~csr_src;
            default: csr_nv = csr_old;
        endcase
    end

    always_comb
    begin
        amo_ok = 1'b1;
        unique case (f5)
            AMO_ADD:  amo_nv = ctx_reg.data + ctx_reg.b;
            AMO_SWAP: amo_nv = ctx_reg.b;
            AMO_XOR:  amo_nv = ctx_reg.data ^ ctx_reg.b;
            AMO_OR:   amo_nv = ctx_reg.data | ctx_reg.b;
            AMO_AND:  amo_nv = ctx_reg.data & ctx_reg.b;
            AMO_MIN:  amo_nv = ($signed(ctx_reg.data) < $signed(ctx_reg.b)) ?
                               ctx_reg.data : ctx_reg.b;
            AMO_MAX:  amo_nv = ($signed(ctx_reg.b) < $signed(ctx_reg.data)) ?
                               ctx_reg.data : ctx_reg.b;
            AMO_MINU: amo_nv = (ctx_reg.data < ctx_reg.b) ? ctx_reg.data : ctx_reg.b;
            AMO_MAXU: amo_nv = (ctx_reg.data > ctx_reg.b) ? ctx_reg.data : ctx_reg.b;
            default:
            begin
                amo_nv = '0;
                amo_ok = 1'b0;
            end
        endcase
    end

    assign csr_idx = (state_reg == S_CLEAR) ? ctx_reg.clr : ins[31:20];

    always_comb
    begin
        state_next = state_reg;
        ctx_next   = ctx_reg;
        mem_we     = 1'b0;
        mem_idx    = mem_addr32[MEM_AW-1:0];
        mem_wd     = '0;
        rf_raddr   = '0;
        rf_we      = 1'b0;
        rf_waddr   = ctx_reg.wrd;
        rf_wd      = ctx_reg.res;
        csr_we     = 1'b0;
        csr_wd     = '0;
        mdu_req    = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                csr_we       = 1'b1;
                ctx_next.clr = ctx_reg.clr + 12'd1;
                if (ctx_reg.clr == 12'hFFF)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctx_next.action = command.action;
                    ctx_next.out    = '0;
                    ctx_next.fault  = 1'b0;
                    ctx_next.st     = ST_OK;
                    ctx_next.wb     = 1'b0;
                    ctx_next.cnt    = '0;
                    ctx_next.n      = 3'd4;
                    ctx_next.data   = '0;
                    ctx_next.ins    = '0;
                    unique case (command.action)
                        ACT_WRITE:
                        begin
                            ctx_next.addr  = command.address;
                            ctx_next.wdata = command.write_word;
                            ctx_next.ret   = S_DONE;
                            if (fits(command.address, 3'd4))
                                state_next = S_MWR;
                            else
                            begin
                                ctx_next.out.status = ST_MEMFAULT;
                                state_next = S_DONE;
                            end
                        end
                        ACT_READ:
                        begin
                            ctx_next.addr   = command.address;
                            ctx_next.to_ins = 1'b0;
                            ctx_next.ret    = S_LOADED;
                            state_next = fits(command.address, 3'd4) ? S_MRD : S_DONE;
                        end
                        ACT_EXEC:
                        begin
                            if (ctx_reg.halted)
                            begin
                                ctx_next.out.status = ST_HALTED;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                ctx_next.out.executed_pc = ctx_reg.pc;
                                ctx_next.addr   = ctx_reg.pc;
                                ctx_next.to_ins = 1'b1;
                                ctx_next.ret    = S_RA;
                                // fetch out of range leaves zero: decodes as illegal
                                state_next = fits(ctx_reg.pc, 3'd4) ? S_MRD : S_RA;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_MRD:
            begin
                // each byte read is captured in the next cycle, while the following read issues
                if (ctx_reg.cnt != 3'd0)
                begin
                    if (ctx_reg.to_ins)
                        ctx_next.ins[bpos +: 8] = mem_q_reg;
                    else
                        ctx_next.data[bpos +: 8] = mem_q_reg;
                end
                if (ctx_reg.cnt == ctx_reg.n)
                    state_next = ctx_reg.ret;
                else
                    ctx_next.cnt = ctx_reg.cnt + 3'd1;
            end
            S_MWR:
            begin
                mem_we = 1'b1;
                mem_wd = ctx_reg.wdata[{ctx_reg.cnt[1:0], 3'b000} +: 8];
                if (ctx_reg.cnt == ctx_reg.n - 3'd1)
                    state_next = ctx_reg.ret;
                else
                    ctx_next.cnt = ctx_reg.cnt + 3'd1;
            end
            S_RA:
            begin
                rf_raddr   = rs1;
                state_next = S_RB;
            end
            S_RB:
            begin
                ctx_next.a = rf_val;
                rf_raddr   = rs2;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                ctx_next.b   = rf_val;
                ctx_next.out.instruction = ins;
                ctx_next.wrd = rd;
                ctx_next.res = '0;
                ctx_next.wb  = 1'b0;
                ctx_next.npc = pc4;
                ctx_next.cnt = '0;
                state_next   = S_WB;
                unique case (opc)
                    OP_LUI:
                    begin
                        ctx_next.res = imm_u;
                        ctx_next.wb  = 1'b1;
                    end
                    OP_AUIPC:
                    begin
                        ctx_next.res = ctx_reg.pc + imm_u;
                        ctx_next.wb  = 1'b1;
                    end
                    OP_JAL:
                    begin
                        ctx_next.res = pc4;
                        ctx_next.wb  = 1'b1;
                        ctx_next.npc = ctx_reg.pc + imm_j;
                    end
                    OP_JALR:
                    begin
                        ctx_next.res = pc4;
                        ctx_next.wb  = 1'b1;
                        ctx_next.npc = (ctx_reg.a + imm_i) & ~32'd1;
                    end
                    OP_BRANCH:
                    begin
                        if (br_take)
                            ctx_next.npc = ctx_reg.pc + imm_b;
                    end
                    OP_LOAD:
                    begin
                        ctx_next.addr   = ld_addr;
                        ctx_next.to_ins = 1'b0;
                        ctx_next.data   = '0;
                        ctx_next.ret    = S_LOADED;
                        ctx_next.n      = (f3[1:0] == 2'd0) ? 3'd1 :
                                          ((f3[1:0] == 2'd1) ? 3'd2 : 3'd4);
                        if (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2 ||
                            f3 == 3'd4 || f3 == 3'd5)
                        begin
                            ctx_next.wb = 1'b1;
                            if (fits(ld_addr, ctx_next.n))
                                state_next = S_MRD;
                        end
                    end
                    OP_STORE:
                    begin
                        ctx_next.addr  = st_addr;
                        ctx_next.wdata = rf_val;
                        ctx_next.ret   = S_WB;
                        ctx_next.n     = (f3 == 3'd0) ? 3'd1 : ((f3 == 3'd1) ? 3'd2 : 3'd4);
                        if (f3 <= 3'd2)
                        begin
                            if (fits(st_addr, ctx_next.n))
                                state_next = S_MWR;
                            else
                                ctx_next.fault = 1'b1;
                        end
                    end
                    OP_IMM:
                    begin
                        ctx_next.res = alu_res;
                        ctx_next.wb  = 1'b1;
                    end
                    OP_REG:
                    begin
                        if (f7 == 7'd1)
                        begin
                            mdu_req.start  = 1'b1;
                            mdu_req.funct3 = f3;
                            mdu_req.a      = ctx_reg.a;
                            mdu_req.b      = rf_val;
                            state_next     = S_MD;
                        end
                        else
                        begin
                            ctx_next.res = alu_res;
                            ctx_next.wb  = 1'b1;
                        end
                    end
                    OP_FENCE: ;
                    OP_SYSTEM:
                    begin
                        if (f3 == 3'd0)
                        begin
                            if (ins == INS_ECALL)
                                state_next = S_ECALL;
                            else
                            begin
                                ctx_next.halted     = 1'b1;
                                ctx_next.out.status = (ins == INS_EBREAK) ? ST_EBREAK :
                                                                            ST_ILLEGAL;
                                state_next = S_DONE;
                            end
                        end
                        else
                            state_next = S_CSR;
                    end
                    OP_AMO:
                    begin
                        ctx_next.addr   = ctx_reg.a;
                        ctx_next.to_ins = 1'b0;
                        ctx_next.data   = '0;
                        ctx_next.n      = 3'd4;
                        ctx_next.ret    = S_AMO;
                        if (f5 == AMO_SC)
                        begin
                            ctx_next.wb    = 1'b1;
                            ctx_next.wdata = rf_val;
                            ctx_next.ret   = S_WB;
                            if (ctx_reg.resv_v && ctx_reg.resv_a == ctx_reg.a)
                            begin
                                ctx_next.res    = 32'd0;
                                ctx_next.resv_v = 1'b0;
                                if (fits(ctx_reg.a, 3'd4))
                                    state_next = S_MWR;
                                else
                                    ctx_next.fault = 1'b1;
                            end
                            else
                                ctx_next.res = 32'd1;
                        end
                        else
                        begin
                            if (f5 == AMO_LR)
                            begin
                                ctx_next.resv_v = 1'b1;
                                ctx_next.resv_a = ctx_reg.a;
                            end
                            state_next = fits(ctx_reg.a, 3'd4) ? S_MRD : S_AMO;
                        end
                    end
                    default:
                    begin
                        ctx_next.halted     = 1'b1;
                        ctx_next.out.status = ST_ILLEGAL;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_LOADED:
            begin
                state_next = S_WB;
                if (ctx_reg.action == ACT_READ)
                begin
                    ctx_next.out.read_word = ctx_reg.data;
                    state_next = S_DONE;
                end
                else
                begin
                    unique case (f3)
                        3'd0:    ctx_next.res = {{24{ctx_reg.data[7]}}, ctx_reg.data[7:0]};
                        3'd1:    ctx_next.res = {{16{ctx_reg.data[15]}}, ctx_reg.data[15:0]};
                        default: ctx_next.res = ctx_reg.data;
                    endcase
                end
            end
            S_MD:
            begin
                if (mdu_rsp.done)
                begin
                    ctx_next.res = mdu_rsp.result;
                    ctx_next.wb  = 1'b1;
                    state_next   = S_WB;
                end
            end
            S_CSR:
            begin
                csr_we       = ((f3[1:0] == 2'd1) || (rs1 != 5'd0)) && !csr_ro;
                csr_wd       = csr_nv;
                ctx_next.res = csr_old;
                ctx_next.wb  = 1'b1;
                state_next   = S_WB;
            end
            S_ECALL:
            begin
                // a7, a0, a1, a2 read one a cycle
                unique case (ctx_reg.cnt)
                    3'd0:    rf_raddr = 5'd17;
                    3'd1:    rf_raddr = 5'd10;
                    3'd2:    rf_raddr = 5'd11;
                    default: rf_raddr = 5'd12;
                endcase
                unique case (ctx_reg.cnt)
                    3'd1:    ctx_next.out.syscall_number = rf_val;
                    3'd2:    ctx_next.out.syscall_arg0   = rf_val;
                    3'd3:    ctx_next.out.syscall_arg1   = rf_val;
                    3'd4:    ctx_next.out.syscall_arg2   = rf_val;
                    default: ;
                endcase
                ctx_next.cnt = ctx_reg.cnt + 3'd1;
                if (ctx_reg.cnt == 3'd4)
                begin
                    ctx_next.wrd = 5'd10;
                    ctx_next.wb  = 1'b1;
                    ctx_next.res = 32'hFFFF_FFFF;
                    state_next   = S_WB;
                    if (ctx_reg.out.syscall_number == SYS_EXIT)
                    begin
                        ctx_next.wb         = 1'b0;
                        ctx_next.halted     = 1'b1;
                        ctx_next.out.status = ST_EXIT;
                        state_next = S_DONE;
                    end
                    else if (ctx_reg.out.syscall_number == SYS_WRITE)
                    begin
                        ctx_next.st = ST_WRITE;
                        if (ctx_reg.out.syscall_arg0 == 32'd1 ||
                            ctx_reg.out.syscall_arg0 == 32'd2)
                            ctx_next.res = rf_val;
                    end
                    else
                        ctx_next.st = ST_SYSCALL;
                end
            end
            S_AMO:
            begin
                state_next = S_WB;
                if (f5 == AMO_LR)
                begin
                    ctx_next.res = ctx_reg.data;
                    ctx_next.wb  = 1'b1;
                end
                else if (amo_ok)
                begin
                    ctx_next.res   = ctx_reg.data;
                    ctx_next.wb    = 1'b1;
                    ctx_next.wdata = amo_nv;
                    ctx_next.cnt   = '0;
                    ctx_next.ret   = S_WB;
                    if (fits(ctx_reg.addr, 3'd4))
                        state_next = S_MWR;
                    else
                        ctx_next.fault = 1'b1;
                end
            end
            S_WB:
            begin
                rf_we        = ctx_reg.wb && (ctx_reg.wrd != 5'd0);
                ctx_next.pc  = ctx_reg.npc;
                ctx_next.cyc = ctx_reg.cyc + 64'd1;
                ctx_next.out.status = ctx_reg.fault ? ST_MEMFAULT : ctx_reg.st;
                state_next   = S_DONE;
            end
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ctx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            main_mem[mem_idx] <= mem_wd;
        mem_q_reg <= main_mem[mem_idx];
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf_mem[rf_waddr] <= rf_wd;
        rf_q_reg <= rf_mem[rf_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
            rf_v_reg     <= 1'b0;
        end
        else
        begin
            if (rf_we)
                rf_valid_reg[rf_waddr] <= 1'b1;
            rf_v_reg <= rf_valid_reg[rf_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (csr_we)
            csr_mem[csr_idx] <= csr_wd;
        csr_q_reg <= csr_mem[csr_idx];
    end

    rvc_mdu u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mdu_req),
        .rsp   (mdu_rsp)
    );

    assign busy     = (state_reg != S_IDLE);
    assign done     = (state_reg == S_DONE);
    assign response = ctx_reg.out;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result word shown for more than one cycle");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the core busy");
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(ctx_reg.halted))
        else $error("halt cleared without reset");
    a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |-> rf_waddr != 5'd0)
        else $error("write to x0");
    a_mwr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MWR |-> ctx_reg.cnt < ctx_reg.n)
        else $error("byte store past access size");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for rv32ima_core_step_core: fills the data window, runs directed
// and random instruction streams, and checks each response word against a predictor.
// Depends on rvc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
    import rvc_pkg::*;

    // most data accesses fall in this window, which is filled first
    localparam int DATA_BYTES = 1024;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    core_in_t  command = '0;
    logic      busy;
    logic      done;
    core_out_t response;

    rv32ima_core_step_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .command  (command),
        .busy     (busy),
        .done     (done),
        .response (response)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // core state as the predictor sees it
    logic [7:0]  mem_img [MEM_BYTES];
    logic [31:0] xreg [32];
    logic [31:0] csr_img [4096];
    logic [31:0] pc_q;
    logic [63:0] cyc_q;
    logic        resv_v;
    logic [31:0] resv_a;
    logic        halt_q;
    logic        fault_q;

    core_in_t  pending_words [$];
    core_out_t expected_resp [$];
    int        n_push = 0;
    int        n_acc = 0;
    int        n_bad = 0;
    int        gap_pct = 12;

    function automatic logic in_mem(logic [31:0] a, int n);
        return ({32'd0, a} + 64'(n)) <= 64'(MEM_BYTES);
    endfunction

    function automatic logic [31:0] mem_rd(logic [31:0] a, int n);
        logic [31:0] v;
        v = '0;
        if (in_mem(a, n))
            for (int i = 0; i < n; i++)
                v |= 32'(mem_img[a + i]) << (8 * i);
        return v;
    endfunction

    function automatic void mem_wr(logic [31:0] a, int n, logic [31:0] v);
        if (!in_mem(a, n))
            fault_q = 1'b1;
        else
            for (int i = 0; i < n; i++)
                mem_img[a + i] = v[8*i +: 8];
    endfunction

    function automatic logic [31:0] sx(logic [31:0] v, int bits);
        logic [31:0] s;
        s = 32'd1 << (bits - 1);
        v &= (s << 1) - 32'd1;
        return (v ^ s) - s;
    endfunction

    function automatic logic lt_s(logic [31:0] a, logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b, logic want_rem);
        logic [31:0] ma, mb, r;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        if (want_rem)
        begin
            r = ma % mb;
            return a[31] ? -r : r;
        end
        r = ma / mb;
        return (a[31] != b[31]) ? -r : r;
    endfunction

    function automatic logic [31:0] csr_rd(logic [11:0] ca);
        case (ca)
            CSR_CYCLE, CSR_MCYCLE, CSR_TIME, CSR_INSTRET, CSR_MINSTRET:
                return cyc_q[31:0];
            CSR_CYCLEH, CSR_MCYCLEH, CSR_TIMEH, CSR_INSTRETH, CSR_MINSTRETH:
                return cyc_q[63:32];
            default:
                return csr_img[ca];
        endcase
    endfunction

    function automatic void csr_wr(logic [11:0] ca, logic [31:0] v);
        case (ca)
            CSR_CYCLE, CSR_CYCLEH, CSR_TIME, CSR_TIMEH, CSR_INSTRET, CSR_INSTRETH: ;
            default: csr_img[ca] = v;
        endcase
    endfunction

    function automatic logic [31:0] amo_calc(logic [4:0] f5, logic [31:0] old,
                                             logic [31:0] src, output logic ok);
        ok = 1'b1;
        case (f5)
            AMO_ADD:  return old + src;
            AMO_SWAP: return src;
            AMO_XOR:  return old ^ src;
            AMO_OR:   return old | src;
            AMO_AND:  return old & src;
            AMO_MIN:  return lt_s(old, src) ? old : src;
            AMO_MAX:  return lt_s(src, old) ? old : src;
            AMO_MINU: return old < src ? old : src;
            AMO_MAXU: return old > src ? old : src;
            default:
            begin
                ok = 1'b0;
                return '0;
            end
        endcase
    endfunction

    function automatic void exec_one(inout core_out_t o);
        logic [31:0] pc, ins, a, b, npc, res, addr, imm, old, nv, src;
        logic [63:0] p;
        logic [6:0]  opc, f7;
        logic [4:0]  rd, rs1, rs2, f5;
        logic [2:0]  f3, st;
        logic        wb, t, ok;
        pc = pc_q;
        ins = mem_rd(pc, 4);
        opc = ins[6:0];
        rd = ins[11:7];
        f3 = ins[14:12];
        rs1 = ins[19:15];
        rs2 = ins[24:20];
        f7 = ins[31:25];
        a = xreg[rs1];
        b = xreg[rs2];
        npc = pc + 32'd4;
        res = '0;
        wb = 1'b0;
        st = ST_OK;
        fault_q = 1'b0;
        o.executed_pc = pc;
        o.instruction = ins;
        imm = sx(ins >> 20, 12);
        case (opc)
            OP_LUI:
            begin
                res = {ins[31:12], 12'd0};
                wb = 1'b1;
            end
            OP_AUIPC:
            begin
                res = pc + {ins[31:12], 12'd0};
                wb = 1'b1;
            end
            OP_JAL:
            begin
                res = npc;
                wb = 1'b1;
                npc = pc + sx({11'd0, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}, 21);
            end
            OP_JALR:
            begin
                res = npc;
                wb = 1'b1;
                npc = (a + imm) & ~32'd1;
            end
            OP_BRANCH:
            begin
                case (f3)
                    3'd0: t = a == b;
                    3'd1: t = a != b;
                    3'd4: t = lt_s(a, b);
                    3'd5: t = !lt_s(a, b);
                    3'd6: t = a < b;
                    3'd7: t = a >= b;
                    default: t = 1'b0;
                endcase
                if (t)
                    npc = pc + sx({19'd0, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}, 13);
            end
            OP_LOAD:
            begin
                addr = a + imm;
                wb = 1'b1;
                case (f3)
                    3'd0: res = sx(mem_rd(addr, 1), 8);
                    3'd1: res = sx(mem_rd(addr, 2), 16);
                    3'd2: res = mem_rd(addr, 4);
                    3'd4: res = mem_rd(addr, 1);
                    3'd5: res = mem_rd(addr, 2);
                    default: wb = 1'b0;
                endcase
            end
            OP_STORE:
            begin
                addr = a + sx({20'd0, ins[31:25], ins[11:7]}, 12);
                if (f3 <= 3'd2)
                    mem_wr(addr, 1 << f3, b);
            end
            OP_IMM:
            begin
                wb = 1'b1;
                case (f3)
                    3'd0: res = a + imm;
                    3'd1: res = a << rs2;
                    3'd2: res = {31'd0, lt_s(a, imm)};
                    3'd3: res = {31'd0, a < imm};
                    3'd4: res = a ^ imm;
                    3'd5: res = (f7 != 0) ? 32'($signed(a) >>> rs2) : a >> rs2;
                    3'd6: res = a | imm;
                    default: res = a & imm;
                endcase
            end
            OP_REG:
            begin
                wb = 1'b1;
                if (f7 == 7'd1)
                begin
                    case (f3)
                        3'd0: res = a * b;
                        3'd1:
                        begin
                            p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
                            res = p[63:32];
                        end
                        3'd2:
                        begin
                            p = {{32{a[31]}}, a} * {32'd0, b};
                            res = p[63:32];
                        end
                        3'd3:
                        begin
                            p = {32'd0, a} * {32'd0, b};
                            res = p[63:32];
                        end
                        3'd4: res = (b != 0) ? sdiv(a, b, 1'b0) : '1;
                        3'd5: res = (b != 0) ? a / b : '1;
                        3'd6: res = (b != 0) ? sdiv(a, b, 1'b1) : a;
                        default: res = (b != 0) ? a % b : a;
                    endcase
                end
                else
                begin
                    case (f3)
                        3'd0: res = (f7 != 0) ? a - b : a + b;
                        3'd1: res = a << b[4:0];
                        3'd2: res = {31'd0, lt_s(a, b)};
                        3'd3: res = {31'd0, a < b};
                        3'd4: res = a ^ b;
                        3'd5: res = (f7 != 0) ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
                        3'd6: res = a | b;
                        default: res = a & b;
                    endcase
                end
            end
            OP_FENCE: ;
            OP_SYSTEM:
            begin
                if (f3 == 3'd0)
                begin
                    if (ins != INS_ECALL)
                    begin
                        halt_q = 1'b1;
                        o.status = (ins == INS_EBREAK) ? ST_EBREAK : ST_ILLEGAL;
                        return;
                    end
                    o.syscall_number = xreg[17];
                    o.syscall_arg0 = xreg[10];
                    o.syscall_arg1 = xreg[11];
                    o.syscall_arg2 = xreg[12];
                    if (xreg[17] == SYS_EXIT)
                    begin
                        halt_q = 1'b1;
                        o.status = ST_EXIT;
                        return;
                    end
                    if (xreg[17] == SYS_WRITE)
                    begin
                        st = ST_WRITE;
                        xreg[10] = (xreg[10] == 1 || xreg[10] == 2) ? xreg[12] : '1;
                    end
                    else
                    begin
                        st = ST_SYSCALL;
                        xreg[10] = '1;
                    end
                end
                else
                begin
                    old = csr_rd(ins[31:20]);
                    nv = old;
                    src = f3[2] ? {27'd0, rs1} : a;
                    case (f3[1:0])
                        2'd1: nv = src;
                        2'd2: nv = old | src;
                        2'd3: nv = old & ~src;
                        default: ;
                    endcase
                    res = old;
                    wb = 1'b1;
                    if (f3[1:0] == 2'd1 || rs1 != 0)
                        csr_wr(ins[31:20], nv);
                end
            end
            OP_AMO:
            begin
                f5 = f7[6:2];
                if (f5 == AMO_LR)
                begin
                    res = mem_rd(a, 4);
                    wb = 1'b1;
                    resv_v = 1'b1;
                    resv_a = a;
                end
                else if (f5 == AMO_SC)
                begin
                    wb = 1'b1;
                    if (resv_v && resv_a == a)
                    begin
                        mem_wr(a, 4, b);
                        res = '0;
                        resv_v = 1'b0;
                    end
                    else
                        res = 32'd1;
                end
                else
                begin
                    old = mem_rd(a, 4);
                    nv = amo_calc(f5, old, b, ok);
                    if (ok)
                    begin
                        mem_wr(a, 4, nv);
                        res = old;
                        wb = 1'b1;
                    end
                end
            end
            default:
            begin
                halt_q = 1'b1;
                o.status = ST_ILLEGAL;
                return;
            end
        endcase
        if (wb && rd != 0)
            xreg[rd] = res;
        xreg[0] = '0;
        pc_q = npc;
        cyc_q++;
        o.status = fault_q ? ST_MEMFAULT : st;
    endfunction

    function automatic core_out_t core_predict(core_in_t c);
        core_out_t o;
        o = '0;
        case (c.action)
            ACT_WRITE:
            begin
                fault_q = 1'b0;
                mem_wr(c.address, 4, c.write_word);
                o.status = fault_q ? ST_MEMFAULT : ST_OK;
            end
            ACT_READ: o.read_word = mem_rd(c.address, 4);
            ACT_EXEC:
            begin
                if (halt_q)
                    o.status = ST_HALTED;
                else
                    exec_one(o);
            end
            default: ;
        endcase
        return o;
    endfunction

    // driver: one word per handshake, random gaps
    always @(posedge clk or negedge rst_n)
    begin : drive
        logic fire;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            fire = start && !busy;
            if (fire)
            begin
                expected_resp.push_back(core_predict(command));
                n_acc++;
            end
            if (!start || fire)
            begin
                if (pending_words.size() != 0 && $urandom_range(99, 0) >= gap_pct)
                begin
                    command <= pending_words.pop_front();
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    task automatic flag(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got %h, want %h", $time, what, got, want);
        n_bad++;
    endtask

    always @(posedge clk)
    begin : watch
        core_out_t want;
        if (rst_n && done)
        begin
            if (expected_resp.size() == 0)
                flag("unexpected response, status", 32'(response.status), '0);
            else
            begin
                want = expected_resp.pop_front();
                if (response.status !== want.status)
                    flag("status", 32'(response.status), 32'(want.status));
                if (response.read_word !== want.read_word)
                    flag("read_word", response.read_word, want.read_word);
                if (response.executed_pc !== want.executed_pc)
                    flag("executed_pc", response.executed_pc, want.executed_pc);
                if (response.instruction !== want.instruction)
                    flag("instruction", response.instruction, want.instruction);
                if (response.syscall_number !== want.syscall_number)
                    flag("syscall_number", response.syscall_number, want.syscall_number);
                if (response.syscall_arg0 !== want.syscall_arg0)
                    flag("syscall_arg0", response.syscall_arg0, want.syscall_arg0);
                if (response.syscall_arg1 !== want.syscall_arg1)
                    flag("syscall_arg1", response.syscall_arg1, want.syscall_arg1);
                if (response.syscall_arg2 !== want.syscall_arg2)
                    flag("syscall_arg2", response.syscall_arg2, want.syscall_arg2);
            end
        end
    end

    // instruction encoders
    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_j(logic [31:0] off, logic [4:0] rd);
        return {off[20], off[10:1], off[11], off[19:12], rd, OP_JAL};
    endfunction

    task automatic push_word(logic [1:0] act, logic [31:0] adr, logic [31:0] w);
        core_in_t c;
        c.action = act;
        c.address = adr;
        c.write_word = w;
        pending_words.push_back(c);
        n_push++;
    endtask

    // wait until every queued word has been taken and predicted
    task automatic settle();
        while (pending_words.size() != 0 || n_acc != n_push)
            @(negedge clk);
    endtask

    task automatic drain();
        settle();
        while (expected_resp.size() != 0)
            @(negedge clk);
    endtask

    // place one instruction at pc and execute it; wrap pc back before the top
    task automatic run_ins(logic [31:0] ins);
        settle();
        if (pc_q + 8 > MEM_BYTES)
        begin
            push_word(ACT_WRITE, pc_q,
                      enc_j(32'(4 * $urandom_range(MEM_BYTES / 8, 0)) - pc_q, 5'd0));
            push_word(ACT_EXEC, $urandom(), $urandom());
            settle();
        end
        push_word(ACT_WRITE, pc_q, ins);
        push_word(ACT_EXEC, $urandom(), $urandom());
    endtask

    task automatic load_reg(logic [4:0] rd, logic [31:0] v);
        logic [31:0] hi;
        hi = v + 32'h800;
        if (rd != 0)
        begin
            run_ins({hi[31:12], rd, OP_LUI});
            run_ins(enc_i(v[11:0], rd, 3'd0, rd, OP_IMM));
        end
    endtask

    function automatic logic [31:0] pick_adr(int n);
        int r;
        r = $urandom_range(99, 0);
        if (r < 88)
            return $urandom_range(DATA_BYTES - n, 0);
        else if (r < 94)
            return MEM_BYTES - n + $urandom_range(3, 1);
        return $urandom_range(32'hFFFF_FFFF, MEM_BYTES);
    endfunction

    function automatic logic [31:0] pick_val();
        case ($urandom_range(5, 0))
            0: return '0;
            1: return 32'h8000_0000;
            2: return '1;
            3: return 32'h7fff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [11:0] pick_csr();
        case ($urandom_range(11, 0))
            0: return CSR_CYCLE;
            1: return CSR_TIME;
            2: return CSR_INSTRET;
            3: return CSR_CYCLEH;
            4: return CSR_TIMEH;
            5: return CSR_INSTRETH;
            6: return CSR_MCYCLE;
            7: return CSR_MINSTRET;
            8: return CSR_MCYCLEH;
            9: return CSR_MINSTRETH;
            10: return 12'h340 + 12'($urandom_range(3, 0));
            default: return 12'($urandom());
        endcase
    endfunction

    function automatic logic [4:0] pick_amo();
        case ($urandom_range(11, 0))
            0: return AMO_ADD;
            1: return AMO_SWAP;
            2: return AMO_XOR;
            3: return AMO_OR;
            4: return AMO_AND;
            5: return AMO_MIN;
            6: return AMO_MAX;
            7: return AMO_MINU;
            8: return AMO_MAXU;
            9: return AMO_LR;
            10: return AMO_SC;
            default: return 5'($urandom());
        endcase
    endfunction

    task automatic random_op();
        int          k, lo_t, hi_t;
        logic [31:0] tgt, imm, num;
        logic [4:0]  rd, rs1, rs2, f5;
        logic [6:0]  f7;
        k = $urandom_range(99, 0);
        rd = 5'($urandom());
        rs1 = 5'($urandom_range(31, 1));
        rs2 = 5'($urandom());
        if (k < 8)
            load_reg(5'($urandom()), pick_val());
        else if (k < 18)
            run_ins(enc_i(12'($urandom()), rs1, 3'($urandom()), rd, OP_IMM));
        else if (k < 33)
        begin
            case ($urandom_range(3, 0))
                0: f7 = 7'h00;
                1: f7 = 7'h20;
                2: f7 = 7'h01;
                default: f7 = 7'($urandom());
            endcase
            run_ins(enc_r(f7, rs2, rs1, 3'($urandom()), rd, OP_REG));
        end
        else if (k < 37)
            run_ins({20'($urandom()), rd, ($urandom_range(1, 0) != 0) ? OP_LUI : OP_AUIPC});
        else if (k < 57)
        begin
            imm = $urandom();
            tgt = pick_adr(4);
            load_reg(rs1, tgt - sx(imm, 12));
            if (k < 47)
                run_ins(enc_i(imm[11:0], rs1, 3'($urandom()), rd, OP_LOAD));
            else
                run_ins({imm[11:5], rs2, rs1, 3'($urandom()), imm[4:0], OP_STORE});
        end
        else if (k < 67)
        begin
            load_reg(rs1, pick_adr(4));
            f5 = pick_amo();
            if (f5 == AMO_SC && $urandom_range(1, 0) != 0)
                run_ins(enc_r({AMO_LR, 2'b00}, 5'd0, rs1, 3'd2, (rd == rs1) ? 5'd0 : rd, OP_AMO));
            run_ins(enc_r({f5, 2'($urandom())}, rs2, rs1, 3'($urandom()), rd, OP_AMO));
        end
        else if (k < 74)
            run_ins(enc_i(pick_csr(), 5'($urandom()), 3'($urandom_range(7, 1)), rd, OP_SYSTEM));
        else if (k < 82)
        begin
            settle();
            lo_t = (pc_q >= 4096) ? int'(pc_q) - 4096 : 0;
            hi_t = (int'(pc_q) + 4092 > MEM_BYTES - 8) ? MEM_BYTES - 8 : int'(pc_q) + 4092;
            tgt = 32'(lo_t + 4 * $urandom_range((hi_t - lo_t) / 4, 0));
            imm = tgt - pc_q;
            if ($urandom_range(3, 0) == 0)
                rs2 = rs1;
            run_ins({imm[12], imm[10:5], rs2, rs1, 3'($urandom()), imm[4:1], imm[11],
                     OP_BRANCH});
        end
        else if (k < 86)
        begin
            settle();
            tgt = 32'(4 * $urandom_range((MEM_BYTES - 8) / 4, 0));
            run_ins(enc_j(tgt - pc_q, rd));
        end
        else if (k < 89)
        begin
            tgt = 32'(4 * $urandom_range((MEM_BYTES - 8) / 4, 0));
            imm = $urandom();
            // bit 0 of the sum is dropped by the jump
            load_reg(rs1, tgt - sx(imm, 12) + 32'($urandom_range(1, 0)));
            run_ins(enc_i(imm[11:0], rs1, 3'd0, rd, OP_JALR));
        end
        else if (k < 90)
            run_ins({25'($urandom()), OP_FENCE});
        else if (k < 94)
        begin
            num = ($urandom_range(2, 0) == 0) ? $urandom_range(200, 0) : SYS_WRITE;
            if (num == SYS_EXIT)
                num = SYS_WRITE;
            load_reg(5'd17, num);
            load_reg(5'd10, ($urandom_range(2, 0) == 0) ? pick_val() : $urandom_range(2, 1));
            load_reg(5'd11, $urandom());
            load_reg(5'd12, pick_val());
            run_ins(INS_ECALL);
        end
        else
        begin
            case ($urandom_range(2, 0))
                0: push_word(ACT_READ, pick_adr(4), $urandom());
                1: push_word(ACT_WRITE, pick_adr(4), $urandom());
                default: push_word(2'd3, $urandom(), $urandom());
            endcase
        end
    endtask

    initial
    begin : gen
        int base;
        for (int i = 0; i < MEM_BYTES; i++)
            mem_img[i] = '0;
        for (int i = 0; i < 32; i++)
            xreg[i] = '0;
        for (int i = 0; i < 4096; i++)
            csr_img[i] = '0;
        pc_q = '0;
        cyc_q = '0;
        resv_v = 1'b0;
        resv_a = '0;
        halt_q = 1'b0;
        fault_q = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // every data byte gets written before anything reads it
        for (int a = 0; a < DATA_BYTES; a += 4)
            push_word(ACT_WRITE, a, $urandom());

        // memory edges, ignored action, division and MULH corner cases
        push_word(ACT_WRITE, 0, '0);
        push_word(ACT_WRITE, MEM_BYTES - 4, '1);
        push_word(ACT_WRITE, MEM_BYTES - 3, '1);
        push_word(ACT_WRITE, '1, 32'h5a5a_a5a5);
        push_word(ACT_READ, 0, '0);
        push_word(ACT_READ, MEM_BYTES - 4, '1);
        push_word(ACT_READ, MEM_BYTES - 3, '0);
        push_word(ACT_READ, 32'hffff_fffc, '0);
        push_word(2'd3, '1, '1);
        load_reg(5'd5, 32'h8000_0000);
        load_reg(5'd6, '1);
        run_ins(enc_r(7'h01, 5'd6, 5'd5, 3'd4, 5'd7, OP_REG));
        run_ins(enc_r(7'h01, 5'd6, 5'd5, 3'd6, 5'd8, OP_REG));
        run_ins(enc_r(7'h01, 5'd0, 5'd5, 3'd4, 5'd9, OP_REG));
        run_ins(enc_r(7'h01, 5'd0, 5'd5, 3'd7, 5'd9, OP_REG));
        run_ins(enc_r(7'h01, 5'd5, 5'd5, 3'd1, 5'd9, OP_REG));
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            gap_pct = (ph == 0) ? 12 : (ph == 1) ? 45 : 0;
            base = n_push;
            while (n_push - base < 120)
                random_op();
            if (ph == 0)
                drain();
        end

        // the core can halt only once, so one halting case closes the run
        case ($urandom_range(4, 0))
            0:
            begin
                load_reg(5'd17, SYS_EXIT);
                run_ins(INS_ECALL);
            end
            1: run_ins(INS_EBREAK);
            2: run_ins(enc_i(12'h302, 5'd0, 3'd0, 5'd0, OP_SYSTEM));
            3: run_ins({25'($urandom()), 7'h5b});
            default:
            begin
                settle();
                push_word(ACT_WRITE, pc_q, enc_j(32'(MEM_BYTES) - pc_q, 5'd1));
                push_word(ACT_EXEC, '0, '0);
                push_word(ACT_EXEC, '0, '0);
            end
        endcase
        repeat (3) run_ins($urandom());
        push_word(ACT_READ, pick_adr(4), '0);
        drain();
        repeat (60) @(posedge clk);
        if (n_bad == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rvc_pkg.sv
rtl/rvc_mdu.sv
rtl/rv32ima_core_step_core.sv
tb/tb_top.sv
